// ===== hdl/psa_pkg.sv =====
`timescale 1ns / 1ps

package psa_pkg;

    // Fixed field widths
    localparam int DATA_W   = 32;
    localparam int MAP_W    = 16;
    localparam int DONE_W   = 32;
    localparam int UNIT_W   = 5;
    localparam int BLK_W    = 4;
    localparam int CFG_IDX_W = 3;

    // Table geometry: {phase, colour, unit}
    localparam int NUM_COLOURS = 2;
    localparam int ADDR_W      = 1 + $clog2(NUM_COLOURS) + UNIT_W;
    localparam int DEPTH       = 1 << ADDR_W;

    // Build constants
    localparam int NUM_UNITS     = 32;
    localparam int NUM_BLOCKS    = 16;
    localparam int ERR_SHIFT     = 12;
    localparam int ACC_WIDTH_DEF = 64;

    // Register indexes on the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FWD_ALL_ARRIVED = 3'd0,
        CFG_BKP_ALL_ARRIVED = 3'd1,
        CFG_FWD_ALL_DONE    = 3'd2,
        CFG_BKP_ALL_DONE    = 3'd3,
        CFG_NET_MAX         = 3'd4,
        CFG_NET_MIN         = 3'd5,
        CFG_FWD_KEY_BASE    = 3'd6,
        CFG_BKP_KEY_BASE    = 3'd7
    } t_cfg_idx;

    // Phase encoding
    localparam logic PHASE_FWD = 1'b0;
    localparam logic PHASE_BKP = 1'b1;

    typedef struct packed {
        logic [MAP_W-1:0]         fwd_all_arrived;
        logic [MAP_W-1:0]         bkp_all_arrived;
        logic [DONE_W-1:0]        fwd_all_done;
        logic [DONE_W-1:0]        bkp_all_done;
        logic signed [DATA_W-1:0] net_max;
        logic signed [DATA_W-1:0] net_min;
        logic [DATA_W-1:0]        fwd_key_base;
        logic [DATA_W-1:0]        bkp_key_base;
    } t_cfg;

    // Completed-sum request handed from the accumulate stage to the output stage
    typedef struct packed {
        logic              emit;
        logic              phase;
        logic [UNIT_W-1:0] unit;
    } t_acc_ctl;

endpackage

// ===== hdl/psa_mem.sv =====
`timescale 1ns / 1ps

module psa_mem
    import psa_pkg::*;
#(
    parameter int DW = ACC_WIDTH_DEF + MAP_W
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [DW-1:0]     i_wr_data,
    output logic [DW-1:0]     o_rd_data
);

    logic [DW-1:0]    r_mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    logic [DW-1:0]    r_rd_data;
    logic [DW-1:0]    r_byp_data;
    logic             r_rd_valid;
    logic             r_byp;

    // Storage and registered read data
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data  <= r_mem[i_rd_addr];
            r_byp_data <= i_wr_data;
        end
    end

    // Entry valid bits; an unwritten entry reads as zero.
    // Write in the read cycle to the same entry is forwarded.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
            r_byp      <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_valid <= r_valid[i_rd_addr];
                r_byp      <= i_wr_en && (i_wr_addr == i_rd_addr);
            end
        end
    end

    assign o_rd_data = r_byp      ? r_byp_data :
                       r_rd_valid ? r_rd_data  : '0;

endmodule

// ===== hdl/psa_acc_stage.sv =====
`timescale 1ns / 1ps

module psa_acc_stage
    import psa_pkg::*;
#(
    parameter int ACC_W = ACC_WIDTH_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_req_vld,
    input  logic                    i_phase,
    input  logic                    i_colour,
    input  logic [BLK_W-1:0]        i_block,
    input  logic [UNIT_W-1:0]       i_unit_index,
    input  logic [DATA_W-1:0]       i_payload,
    input  t_cfg                    i_cfg,
    input  logic [ACC_W+MAP_W-1:0]  i_rd_data,
    output logic                    o_wr_en,
    output logic [ADDR_W-1:0]       o_wr_addr,
    output logic [ACC_W+MAP_W-1:0]  o_wr_data,
    output t_acc_ctl                o_ctl,
    output logic [ACC_W-1:0]        o_sum
);

    logic                r_vld;
    logic                r_phase;
    logic                r_colour;
    logic [BLK_W-1:0]    r_block;
    logic [UNIT_W-1:0]   r_unit;
    logic [DATA_W-1:0]   r_payload;
    t_acc_ctl            r_ctl;
    logic [ACC_W-1:0]    r_sum;

    logic [ACC_W-1:0]    old_sum;
    logic [MAP_W-1:0]    old_map;
    logic [ACC_W-1:0]    n_sum;
    logic [MAP_W-1:0]    n_map;
    logic                full;

    // Request register, lined up with the table read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_req_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_phase   <= i_phase;
        r_colour  <= i_colour;
        r_block   <= i_block;
        r_unit    <= i_unit_index;
        r_payload <= i_payload;
    end

    // Read-modify-write of the entry
    always_comb begin
        old_sum = i_rd_data[ACC_W-1:0];
        old_map = i_rd_data[ACC_W +: MAP_W];
        n_sum   = old_sum + {{(ACC_W-DATA_W){r_payload[DATA_W-1]}}, r_payload};
        n_map   = old_map | (MAP_W'(1) << r_block);
        full    = (r_phase == PHASE_BKP) ? (n_map == i_cfg.bkp_all_arrived)
                                         : (n_map == i_cfg.fwd_all_arrived);
    end

    assign o_wr_en   = r_vld;
    assign o_wr_addr = {r_phase, r_colour, r_unit};
    // a completed sum clears its entry
    assign o_wr_data = full ? '0 : {n_map, n_sum};

    // Hand completed sums on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl.emit  <= r_vld && full;
            r_ctl.phase <= r_phase;
            r_ctl.unit  <= r_unit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum <= n_sum;
    end

    assign o_ctl = r_ctl;
    assign o_sum = r_sum;

endmodule

// ===== hdl/psa_out_stage.sv =====
`timescale 1ns / 1ps

module psa_out_stage
    import psa_pkg::*;
#(
    parameter int ACC_W = ACC_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_acc_ctl           i_ctl,
    input  logic [ACC_W-1:0]   i_sum,
    input  t_cfg               i_cfg,
    output logic               o_valid,
    output logic [DATA_W-1:0]  o_packet_key,
    output logic [DATA_W-1:0]  o_value,
    output logic               o_tick_done
);

    logic [DONE_W-1:0]       r_net_done;
    logic [DONE_W-1:0]       r_err_done;
    logic                    r_valid;
    logic                    r_tick;
    logic [DATA_W-1:0]       r_key;
    logic [DATA_W-1:0]       r_value;

    logic signed [ACC_W-1:0] sum_s;
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    logic signed [ACC_W-1:0] shifted;
    logic [DONE_W-1:0]       done_cur;
    logic [DONE_W-1:0]       n_done;
    logic                    all_done;
    logic [DATA_W-1:0]       n_value;
    logic [DATA_W-1:0]       n_key;

    // Result value: saturate the net, scale the error
    always_comb begin
        sum_s   = signed'(i_sum);
        hi      = ACC_W'(i_cfg.net_max);
        lo      = ACC_W'(i_cfg.net_min);
        shifted = sum_s >>> ERR_SHIFT;
        if (i_ctl.phase == PHASE_BKP) begin
            n_value = shifted[DATA_W-1:0];
        end else if (sum_s >= hi) begin
            n_value = i_cfg.net_max;
        end else if (sum_s <= lo) begin
            n_value = i_cfg.net_min;
        end else begin
            n_value = i_sum[DATA_W-1:0];
        end
    end

    // Done map of the phase and routing key
    always_comb begin
        done_cur = (i_ctl.phase == PHASE_BKP) ? r_err_done : r_net_done;
        n_done   = done_cur | (DONE_W'(1) << i_ctl.unit);
        all_done = (i_ctl.phase == PHASE_BKP) ? (n_done == i_cfg.bkp_all_done)
                                              : (n_done == i_cfg.fwd_all_done);
        n_key    = ((i_ctl.phase == PHASE_BKP) ? i_cfg.bkp_key_base : i_cfg.fwd_key_base)
                   | DATA_W'(i_ctl.unit);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_net_done <= '0;
            r_err_done <= '0;
            r_valid    <= 1'b0;
            r_tick     <= 1'b0;
        end else begin
            r_valid <= i_ctl.emit;
            r_tick  <= i_ctl.emit && all_done;
            if (i_ctl.emit) begin
                if (i_ctl.phase == PHASE_BKP) begin
                    r_err_done <= all_done ? '0 : n_done;
                end else begin
                    r_net_done <= all_done ? '0 : n_done;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_key   <= n_key;
        r_value <= n_value;
    end

    assign o_valid      = r_valid;
    assign o_packet_key = r_key;
    assign o_value      = r_value;
    assign o_tick_done  = r_tick;

endmodule

// ===== hdl/partial_sum_scoreboard_accumulator_top.sv =====
`timescale 1ns / 1ps

// Partial-sum scoreboard accumulator. One request is taken in every clock
// cycle (busy stays low); a request whose unit or block is out of range is
// dropped. The per-(phase, colour, unit) sums and arrival maps live in a
// 128-entry table that is read at the accept edge and written back in the
// following cycle, with a forward path so back-to-back requests to one entry
// chain correctly. Entry valid bits clear the table at reset, so no clearing
// pass is needed. When a request completes an arrival map, its result goes
// via the control and output registers to o_valid for a single cycle;
// the receiver cannot stall results. Registers on the write port may only be
// changed while no request is in flight.
module partial_sum_scoreboard_accumulator_top
    import psa_pkg::*;
#(
    parameter int ACC_WIDTH = ACC_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // request
    input  logic                 start,
    output logic                 busy,
    input  logic                 i_phase,
    input  logic                 i_colour,
    input  logic [BLK_W-1:0]     i_block,
    input  logic [UNIT_W-1:0]    i_unit_index,
    input  logic [DATA_W-1:0]    i_payload,
    // configuration
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [DATA_W-1:0]    i_cfg_data,
    // result
    output logic                 o_valid,
    output logic [DATA_W-1:0]    o_packet_key,
    output logic [DATA_W-1:0]    o_value,
    output logic                 o_tick_done
);

    localparam int RANGE_W = 6;

    t_cfg                        r_cfg;
    logic                        accept;
    logic                        in_range;
    logic [ACC_WIDTH+MAP_W-1:0]  w_rd_data;
    logic                        w_wr_en;
    logic [ADDR_W-1:0]           w_wr_addr;
    logic [ACC_WIDTH+MAP_W-1:0]  w_wr_data;
    t_acc_ctl                    w_ctl;
    logic [ACC_WIDTH-1:0]        w_sum;

    // Fully pipelined, never stalls
    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign in_range = (RANGE_W'(i_unit_index) < RANGE_W'(NUM_UNITS)) &&
                      (RANGE_W'(i_block) < RANGE_W'(NUM_BLOCKS));

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fwd_all_arrived <= '1;
            r_cfg.bkp_all_arrived <= '1;
            r_cfg.fwd_all_done    <= '1;
            r_cfg.bkp_all_done    <= '1;
            r_cfg.net_max         <= {1'b0, {(DATA_W-1){1'b1}}};
            r_cfg.net_min         <= {1'b1, {(DATA_W-1){1'b0}}};
            r_cfg.fwd_key_base    <= '0;
            r_cfg.bkp_key_base    <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_FWD_ALL_ARRIVED: r_cfg.fwd_all_arrived <= i_cfg_data[MAP_W-1:0];
                CFG_BKP_ALL_ARRIVED: r_cfg.bkp_all_arrived <= i_cfg_data[MAP_W-1:0];
                CFG_FWD_ALL_DONE:    r_cfg.fwd_all_done    <= i_cfg_data;
                CFG_BKP_ALL_DONE:    r_cfg.bkp_all_done    <= i_cfg_data;
                CFG_NET_MAX:         r_cfg.net_max         <= i_cfg_data;
                CFG_NET_MIN:         r_cfg.net_min         <= i_cfg_data;
                CFG_FWD_KEY_BASE:    r_cfg.fwd_key_base    <= i_cfg_data;
                CFG_BKP_KEY_BASE:    r_cfg.bkp_key_base    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Sum / arrival-map table
    psa_mem #(
        .DW (ACC_WIDTH + MAP_W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (accept),
        .i_rd_addr ({i_phase, i_colour, i_unit_index}),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .o_rd_data (w_rd_data)
    );

    // Accumulate and arrival check
    psa_acc_stage #(
        .ACC_W (ACC_WIDTH)
    ) u_acc (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_vld    (accept && in_range),
        .i_phase      (i_phase),
        .i_colour     (i_colour),
        .i_block      (i_block),
        .i_unit_index (i_unit_index),
        .i_payload    (i_payload),
        .i_cfg        (r_cfg),
        .i_rd_data    (w_rd_data),
        .o_wr_en      (w_wr_en),
        .o_wr_addr    (w_wr_addr),
        .o_wr_data    (w_wr_data),
        .o_ctl        (w_ctl),
        .o_sum        (w_sum)
    );

    // Result formatting and done tracking
    psa_out_stage #(
        .ACC_W (ACC_WIDTH)
    ) u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (w_ctl),
        .i_sum        (w_sum),
        .i_cfg        (r_cfg),
        .o_valid      (o_valid),
        .o_packet_key (o_packet_key),
        .o_value      (o_value),
        .o_tick_done  (o_tick_done)
    );

    // A result always traces back to an earlier accepted request
    a_result_from_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, 3))
        else $error("result without a matching request");

    // Table write-back only in the cycle after an accepted request
    a_wb_from_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr_en |-> $past(start && !busy, 1))
        else $error("table write without a request");

    // Tick completion only travels with a result
    a_tick_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_tick_done |-> o_valid)
        else $error("tick_done without result strobe");

endmodule
